// ===== rtl/lrupr_pkg.sv =====
// Package for the LRU page replacement block.
// Holds the chain flag and update control structs shared by the cell and the top level.
package lrupr_pkg;

  localparam int FAULT_W    = 32;
  localparam int SLOT_OUT_W = 2;

  typedef struct packed {
    logic hit_seen;
    logic free_seen;
  } chain_t;

  typedef struct packed {
    logic en;
    logic age_all;
  } upd_t;

endpackage

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement: out_valid rises in the cycle after start, one item per cycle.
// busy stays low; the cell row resolves combinationally and updates its registers on each accepted start.
// Synchronous active-low reset empties all frames and clears the fault count.
// Depends on lrupr_pkg and lrupr_cell.
module lru_page_replacement #(
  parameter int NUM_FRAMES = 4,
  parameter int PAGE_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [PAGE_BITS-1:0]              in_page,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [lrupr_pkg::SLOT_OUT_W-1:0]  out_frame_slot,
  output logic                              out_evicted_valid,
  output logic [PAGE_BITS-1:0]              out_evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]     out_fault_total
);
  import lrupr_pkg::*;

  localparam int IDX_W = $clog2(NUM_FRAMES);

  chain_t               chain   [NUM_FRAMES+1];
  logic [IDX_W-1:0]     hit_idx [NUM_FRAMES+1];
  logic [IDX_W-1:0]     hit_rank[NUM_FRAMES+1];
  logic [IDX_W-1:0]     free_idx[NUM_FRAMES+1];
  logic [IDX_W-1:0]     best_idx[NUM_FRAMES+1];
  logic [IDX_W-1:0]     best_rnk[NUM_FRAMES+1];
  logic [PAGE_BITS-1:0] best_pg [NUM_FRAMES+1];

  upd_t                 upd;
  logic [IDX_W-1:0]     sel_idx;
  logic [IDX_W-1:0]     limit;
  logic                 is_hit;
  logic                 evict;
  logic                 accept;

  logic [FAULT_W-1:0]   fault_r, fault_nxt;
  logic                 ov_r;
  logic                 hit_r;
  logic [IDX_W-1:0]     slot_r;
  logic                 ev_r;
  logic [PAGE_BITS-1:0] evpg_r;
  logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;

  assign chain[0]    = '0;
  assign hit_idx[0]  = '0;
  assign hit_rank[0] = '0;
  assign free_idx[0] = '0;
  assign best_idx[0] = '0;
  assign best_rnk[0] = '0;
  assign best_pg[0]  = '0;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W),
      .CELL_IDX  (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .page_i      (in_page),
      .chain_i     (chain[i]),
      .hit_idx_i   (hit_idx[i]),
      .hit_rank_i  (hit_rank[i]),
      .free_idx_i  (free_idx[i]),
      .best_idx_i  (best_idx[i]),
      .best_rank_i (best_rnk[i]),
      .best_page_i (best_pg[i]),
      .chain_o     (chain[i+1]),
      .hit_idx_o   (hit_idx[i+1]),
      .hit_rank_o  (hit_rank[i+1]),
      .free_idx_o  (free_idx[i+1]),
      .best_idx_o  (best_idx[i+1]),
      .best_rank_o (best_rnk[i+1]),
      .best_page_o (best_pg[i+1]),
      .upd_i       (upd),
      .sel_idx_i   (sel_idx),
      .limit_i     (limit)
    );
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_hit = chain[NUM_FRAMES].hit_seen;
  assign evict  = !is_hit && !chain[NUM_FRAMES].free_seen;

  always_comb begin
    upd.en      = accept;
    upd.age_all = 1'b0;
    if (is_hit) begin
      sel_idx = hit_idx[NUM_FRAMES];
      limit   = hit_rank[NUM_FRAMES];
    end else if (!evict) begin
      sel_idx     = free_idx[NUM_FRAMES];
      limit       = '0;
      upd.age_all = 1'b1;
    end else begin
      sel_idx = best_idx[NUM_FRAMES];
      limit   = best_rnk[NUM_FRAMES];
    end
  end

  always_comb begin
    fault_nxt = fault_r;
    if (accept && !is_hit && fault_r != '1) begin
      fault_nxt = fault_r + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      fault_r <= fault_nxt;
      ov_r    <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r  <= is_hit;
      slot_r <= sel_idx;
      ev_r   <= evict;
      evpg_r <= evict ? best_pg[NUM_FRAMES] : '0;
    end
  end

  assign slot_ext          = {{SLOT_OUT_W{1'b0}}, slot_r};
  assign out_valid         = ov_r;
  assign out_hit           = hit_r;
  assign out_frame_slot    = slot_ext[SLOT_OUT_W-1:0];
  assign out_evicted_valid = ev_r;
  assign out_evicted_page  = evpg_r;
  assign out_fault_total   = fault_r;

endmodule

// ===== rtl/lrupr_cell.sv =====
// One frame cell of the LRU chain: page, valid mark and recency rank.
// Forwards hit, first-free and oldest-frame search along the row; depends on lrupr_pkg.
module lrupr_cell #(
  parameter int PAGE_BITS = 8,
  parameter int IDX_W     = 2,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [PAGE_BITS-1:0] page_i,
  input  lrupr_pkg::chain_t    chain_i,
  input  logic [IDX_W-1:0]     hit_idx_i,
  input  logic [IDX_W-1:0]     hit_rank_i,
  input  logic [IDX_W-1:0]     free_idx_i,
  input  logic [IDX_W-1:0]     best_idx_i,
  input  logic [IDX_W-1:0]     best_rank_i,
  input  logic [PAGE_BITS-1:0] best_page_i,
  output lrupr_pkg::chain_t    chain_o,
  output logic [IDX_W-1:0]     hit_idx_o,
  output logic [IDX_W-1:0]     hit_rank_o,
  output logic [IDX_W-1:0]     free_idx_o,
  output logic [IDX_W-1:0]     best_idx_o,
  output logic [IDX_W-1:0]     best_rank_o,
  output logic [PAGE_BITS-1:0] best_page_o,
  input  lrupr_pkg::upd_t      upd_i,
  input  logic [IDX_W-1:0]     sel_idx_i,
  input  logic [IDX_W-1:0]     limit_i
);
  import lrupr_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic [IDX_W-1:0]     rank_r;
  logic                 my_hit;
  logic                 my_free;
  logic                 older;

  assign my_hit  = valid_r && (page_r == page_i) && !chain_i.hit_seen;
  assign my_free = !valid_r && !chain_i.free_seen;
  assign older   = rank_r > best_rank_i;

  always_comb begin
    chain_o.hit_seen  = chain_i.hit_seen | my_hit;
    chain_o.free_seen = chain_i.free_seen | my_free;
    hit_idx_o         = my_hit ? MY_IDX : hit_idx_i;
    hit_rank_o        = my_hit ? rank_r : hit_rank_i;
    free_idx_o        = my_free ? MY_IDX : free_idx_i;
    best_idx_o        = older ? MY_IDX : best_idx_i;
    best_rank_o       = older ? rank_r : best_rank_i;
    best_page_o       = older ? page_r : best_page_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (upd_i.en) begin
      if (sel_idx_i == MY_IDX) begin
        valid_r <= 1'b1;
        rank_r  <= '0;
      end else if (valid_r && (upd_i.age_all || rank_r < limit_i)) begin
        rank_r <= rank_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_i.en && sel_idx_i == MY_IDX) begin
      page_r <= page_i;
    end
  end

endmodule
